// ===== design/csma_pkg.sv =====
// Shared types, register indexes and reset values of the CSMA backoff station.
package csma_pkg;

  localparam int unsigned CW_MIN_DEFAULT = 15;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LEN        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AIFS_EXTRA      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TX_DURATION     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_INTERVAL = 2'd3;

  localparam logic [7:0]  SLOT_LEN_RESET        = 8'd13;
  localparam logic [7:0]  AIFS_EXTRA_RESET      = 8'd32;
  localparam logic [15:0] TX_DURATION_RESET     = 16'd670;
  localparam logic [19:0] PACKET_INTERVAL_RESET = 20'd100000;

  localparam logic [1:0] MAC_SENSE   = 2'd0;
  localparam logic [1:0] MAC_BACKOFF = 2'd1;
  localparam logic [1:0] MAC_TX      = 2'd2;

  typedef struct packed {
    logic [7:0]  slot_len;
    logic [7:0]  aifs_extra;
    logic [15:0] tx_duration;
    logic [19:0] packet_interval;
  } cfg_t;

  typedef enum logic [2:0] {
    MODE_SENSE   = 3'b001,
    MODE_BACKOFF = 3'b010,
    MODE_TX      = 3'b100
  } mode_t;

endpackage

// ===== design/csma_tick_if.sv =====
// Tick channel: one beat per microsecond of channel time.
interface csma_tick_if;
  logic        valid;
  logic        ready;
  logic        channel_busy;
  logic [15:0] random_value;

  modport source (output valid, output channel_busy, output random_value, input ready);
  modport sink (input valid, input channel_busy, input random_value, output ready);
endinterface

// ===== design/csma_result_if.sv =====
// Result channel: the station state after each tick, one beat per tick.
interface csma_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mac_mode;
  logic        tx_start;
  logic [4:0]  backoff_left;
  logic [7:0]  pending_packets;
  logic [15:0] sent_count;

  modport source (output valid, output mac_mode, output tx_start, output backoff_left,
                  output pending_packets, output sent_count, input ready);
  modport sink (input valid, input mac_mode, input tx_start, input backoff_left,
                input pending_packets, input sent_count, output ready);
endinterface

// ===== design/csma_cfg_regs.sv =====
// Configuration register file of the CSMA backoff station.
module csma_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [csma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data,
  output csma_pkg::cfg_t                   cfg
);
  import csma_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_len        <= SLOT_LEN_RESET;
      cfg.aifs_extra      <= AIFS_EXTRA_RESET;
      cfg.tx_duration     <= TX_DURATION_RESET;
      cfg.packet_interval <= PACKET_INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SLOT_LEN: begin
          cfg.slot_len <= cfg_data[7:0];
        end
        CFG_AIFS_EXTRA: begin
          cfg.aifs_extra <= cfg_data[7:0];
        end
        CFG_TX_DURATION: begin
          cfg.tx_duration <= cfg_data[15:0];
        end
        CFG_PACKET_INTERVAL: begin
          cfg.packet_interval <= cfg_data[19:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/csma_mod_unit.sv =====
// Three-stage pipeline that reduces each random value modulo the contention window.
module csma_mod_unit #(
  parameter int unsigned CW_MIN = csma_pkg::CW_MIN_DEFAULT,
  localparam int unsigned CW    = (CW_MIN == 0) ? 1 : CW_MIN,
  localparam int unsigned REM_W = ($clog2(CW) > 0) ? $clog2(CW) : 1
) (
  input  logic             clk,
  input  logic             rst,
  csma_tick_if.sink        tick,
  output logic             prep_valid,
  input  logic             prep_ready,
  output logic             prep_busy,
  output logic [REM_W-1:0] prep_rem
);
  import csma_pkg::*;

  // Reciprocal estimate: the quotient comes out exact or one short.
  localparam int unsigned SHIFT = 26;
  localparam logic [SHIFT:0] RECIP = (SHIFT+1)'((64'd1 << SHIFT) / CW);

  logic        s1_valid, s2_valid, s3_valid;
  logic        s1_busy, s2_busy, s3_busy;
  logic [15:0] s1_rnd, s2_rnd;
  logic [15:0] s2_quot;
  logic [REM_W-1:0] s3_rem;

  logic s1_load, s2_load, s3_load;
  logic [SHIFT+16:0] prod;
  logic [15:0] quot;
  logic [15:0] qmul;
  logic [15:0] diff;
  logic [15:0] rem_full;

  assign s3_load = !s3_valid || prep_ready;
  assign s2_load = !s2_valid || s3_load;
  assign s1_load = !s1_valid || s2_load;
  assign tick.ready = s1_load;

  assign prod = (SHIFT+17)'(s1_rnd) * (SHIFT+17)'(RECIP);
  assign quot = prod[SHIFT+15:SHIFT];

  assign qmul = 16'(26'(s2_quot) * 26'(CW));
  assign diff = s2_rnd - qmul;
  assign rem_full = (diff >= 16'(CW)) ? (diff - 16'(CW)) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= tick.valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (s3_load) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_busy <= tick.channel_busy;
      s1_rnd  <= tick.random_value;
    end
    if (s2_load) begin
      s2_busy <= s1_busy;
      s2_rnd  <= s1_rnd;
      s2_quot <= quot;
    end
    if (s3_load) begin
      s3_busy <= s2_busy;
      s3_rem  <= REM_W'(rem_full);
    end
  end

  assign prep_valid = s3_valid;
  assign prep_busy  = s3_busy;
  assign prep_rem   = s3_rem;

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (32'(s3_rem) < CW))
    else $error("remainder not below the contention window");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    s3_valid && !prep_ready |=> s3_valid && $stable(s3_rem) && $stable(s3_busy))
    else $error("stalled remainder stage lost its beat");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> s1_valid)
    else $error("accepted tick did not enter the first stage");

endmodule

// ===== design/csma_mac_core.sv =====
// Per-tick MAC state update and the result register.
module csma_mac_core #(
  parameter int unsigned CW_MIN = csma_pkg::CW_MIN_DEFAULT,
  localparam int unsigned CW    = (CW_MIN == 0) ? 1 : CW_MIN,
  localparam int unsigned REM_W = ($clog2(CW) > 0) ? $clog2(CW) : 1,
  localparam int unsigned BC_W  = $clog2(CW + 2)
) (
  input  logic             clk,
  input  logic             rst,
  input  csma_pkg::cfg_t   cfg,
  input  logic             prep_valid,
  output logic             prep_ready,
  input  logic             prep_busy,
  input  logic [REM_W-1:0] prep_rem,
  csma_result_if.source    result
);
  import csma_pkg::*;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  mode_t       mode, mode_next;
  logic [7:0]  slot_phase, slot_phase_next;
  logic [19:0] gen_phase, gen_phase_next;
  logic [7:0]  idle_slots, idle_slots_next;
  logic [BC_W-1:0] backoff_count, backoff_count_next;
  logic        frozen, frozen_next;
  logic [7:0]  freeze_slots, freeze_slots_next;
  logic [7:0]  queued, queued_next;
  logic [15:0] tx_elapsed, tx_elapsed_next;
  logic [15:0] sent_total, sent_total_next;
  logic        out_valid;

  logic        take;
  logic        start;
  logic        phase_set;
  logic        try_count;
  logic        boundary;
  logic        reached;
  logic [7:0]  sl;
  logic [19:0] pi;
  logic [15:0] td;
  logic [9:0]  need;
  logic [7:0]  queued_gen;
  logic [7:0]  idle_inc, freeze_inc, idle_cnt;
  logic [BC_W-1:0] bc_dec;
  logic [15:0] tx_inc;
  logic [1:0]  mode_code;
  logic [BC_W+4:0] bc_wide;

  assign take = prep_valid && prep_ready;
  assign prep_ready = !out_valid || result.ready;

  assign sl = (cfg.slot_len == 8'd0) ? 8'd1 : cfg.slot_len;
  assign pi = (cfg.packet_interval == 20'd0) ? 20'd1 : cfg.packet_interval;
  assign td = (cfg.tx_duration == 16'd0) ? 16'd1 : cfg.tx_duration;
  assign need = {1'b0, sl, 1'b0} + 10'(cfg.aifs_extra);
  assign boundary = (slot_phase == 8'd0);

  assign idle_inc   = sat_inc8(idle_slots);
  assign freeze_inc = sat_inc8(freeze_slots);
  // Only one idle counter is live in any mode, so one multiplier serves both.
  assign idle_cnt = (mode == MODE_BACKOFF) ? freeze_inc : idle_inc;
  assign reached  = (idle_cnt == 8'hFF) || ((16'(idle_cnt) * 16'(sl)) >= 16'(need));

  assign bc_dec = (backoff_count != '0) ? backoff_count - BC_W'(1) : backoff_count;
  assign tx_inc = (tx_elapsed != 16'hFFFF) ? tx_elapsed + 16'd1 : tx_elapsed;
  assign queued_gen = ((gen_phase == 20'd0) && (queued != 8'hFF)) ? queued + 8'd1 : queued;

  always_comb begin
    mode_next          = mode;
    idle_slots_next    = idle_slots;
    backoff_count_next = backoff_count;
    frozen_next        = frozen;
    freeze_slots_next  = freeze_slots;
    queued_next        = queued_gen;
    tx_elapsed_next    = tx_elapsed;
    sent_total_next    = sent_total;
    slot_phase_next    = slot_phase;
    start              = 1'b0;
    phase_set          = 1'b0;
    try_count          = 1'b0;

    gen_phase_next = ((21'(gen_phase) + 21'd1) >= 21'(pi)) ? 20'd0 : gen_phase + 20'd1;

    case (mode)
      MODE_BACKOFF: begin
        if (boundary) begin
          if (!prep_busy) begin
            if (!frozen) begin
              try_count = 1'b1;
            end else begin
              freeze_slots_next = freeze_inc;
              if (reached) begin
                frozen_next = 1'b0;
                try_count   = 1'b1;
              end
            end
          end else begin
            frozen_next       = 1'b1;
            freeze_slots_next = 8'd0;
          end
          if (try_count) begin
            backoff_count_next = bc_dec;
            if ((bc_dec == '0) && (queued_gen != 8'd0)) begin
              mode_next       = MODE_TX;
              tx_elapsed_next = 16'd0;
              queued_next     = queued_gen - 8'd1;
              sent_total_next = sent_total + 16'd1;
              start           = 1'b1;
            end
          end
        end
      end
      MODE_TX: begin
        tx_elapsed_next = tx_inc;
        if (tx_inc >= td) begin
          mode_next       = MODE_SENSE;
          idle_slots_next = 8'd0;
          // The first sensing boundary falls one full slot after the end tick.
          slot_phase_next = (sl == 8'd1) ? 8'd0 : 8'd1;
          phase_set       = 1'b1;
        end
      end
      MODE_SENSE: begin
        if (boundary) begin
          if (!prep_busy) begin
            idle_slots_next = idle_inc;
            if (reached) begin
              mode_next          = MODE_BACKOFF;
              backoff_count_next = BC_W'(prep_rem) + BC_W'(2);
              frozen_next        = 1'b0;
              freeze_slots_next  = 8'd0;
            end
          end else begin
            idle_slots_next = 8'd0;
          end
        end
      end
      default: begin
        mode_next = MODE_SENSE;
      end
    endcase

    if (!phase_set) begin
      slot_phase_next = ((9'(slot_phase) + 9'd1) >= 9'(sl)) ? 8'd0 : slot_phase + 8'd1;
    end
  end

  always_comb begin
    case (mode_next)
      MODE_BACKOFF: mode_code = MAC_BACKOFF;
      MODE_TX:      mode_code = MAC_TX;
      default:      mode_code = MAC_SENSE;
    endcase
  end

  assign bc_wide = {5'd0, backoff_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SENSE;
      slot_phase    <= 8'd0;
      gen_phase     <= 20'd0;
      idle_slots    <= 8'd0;
      backoff_count <= '0;
      frozen        <= 1'b0;
      freeze_slots  <= 8'd0;
      queued        <= 8'd0;
      tx_elapsed    <= 16'd0;
      sent_total    <= 16'd0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        mode          <= mode_next;
        slot_phase    <= slot_phase_next;
        gen_phase     <= gen_phase_next;
        idle_slots    <= idle_slots_next;
        backoff_count <= backoff_count_next;
        frozen        <= frozen_next;
        freeze_slots  <= freeze_slots_next;
        queued        <= queued_next;
        tx_elapsed    <= tx_elapsed_next;
        sent_total    <= sent_total_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.mac_mode        <= mode_code;
      result.tx_start        <= start;
      result.backoff_left    <= bc_wide[4:0];
      result.pending_packets <= queued_next;
      result.sent_count      <= sent_total_next;
    end
  end

  assign result.valid = out_valid;

  a_frozen_only_in_backoff: assert property (@(posedge clk) disable iff (rst)
    frozen |-> (mode == MODE_BACKOFF))
    else $error("freeze flag set outside backoff");

  a_state_moves_on_beat: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(mode) && $stable(queued) && $stable(sent_total))
    else $error("station state changed without a tick beat");

  a_start_counts: assert property (@(posedge clk) disable iff (rst)
    take && start |=> (sent_total == $past(sent_total) + 16'd1) && (mode == MODE_TX))
    else $error("transmission start not counted");

  a_start_in_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.tx_start |-> (result.mac_mode == MAC_TX))
    else $error("start flag shown outside transmit mode");

endmodule

// ===== design/csma_backoff_station.sv =====
// CSMA backoff station: accepts one tick per clock cycle when the result side keeps up;
// each tick passes through the pipeline that reduces random_value modulo CW_MIN and then
// through the state update that registers the result. Up to four ticks are in flight,
// ticks are processed strictly in order, and configuration writes take effect from the
// next tick that reaches the state update, so they belong to idle periods.
module csma_backoff_station #(
  parameter int unsigned CW_MIN = csma_pkg::CW_MIN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  csma_tick_if.sink                        tick,
  csma_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [csma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import csma_pkg::*;

  localparam int unsigned CW    = (CW_MIN == 0) ? 1 : CW_MIN;
  localparam int unsigned REM_W = ($clog2(CW) > 0) ? $clog2(CW) : 1;

  cfg_t             cfg;
  logic             prep_valid;
  logic             prep_ready;
  logic             prep_busy;
  logic [REM_W-1:0] prep_rem;

  csma_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csma_mod_unit #(.CW_MIN(CW_MIN)) u_mod (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep_busy  (prep_busy),
    .prep_rem   (prep_rem)
  );

  csma_mac_core #(.CW_MIN(CW_MIN)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .prep_valid (prep_valid),
    .prep_ready (prep_ready),
    .prep_busy  (prep_busy),
    .prep_rem   (prep_rem),
    .result     (result)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the CSMA backoff station: tick beats in, state beats checked out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csma_pkg::*;

  typedef struct packed {
    logic        busy;
    logic [15:0] rnd;
  } tick_beat_t;

  typedef struct packed {
    logic [1:0]  mac_mode;
    logic        tx_start;
    logic [4:0]  backoff_left;
    logic [7:0]  pending_packets;
    logic [15:0] sent_count;
  } station_beat_t;

  localparam int unsigned CW          = CW_MIN_DEFAULT;
  localparam int unsigned MAX_WAIT    = 19;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned LONG_HOLD   = 160;
  localparam int unsigned SHOWN_LIMIT = 10;
  localparam int unsigned SETTLE      = 6;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  csma_tick_if   tick_ch();
  csma_result_if result_ch();

  csma_backoff_station dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and station state as the predictor sees them.
  logic [7:0]  slot_len_q;
  logic [7:0]  aifs_q;
  logic [15:0] tx_dur_q;
  logic [19:0] interval_q;
  logic [1:0]  stn_mode;
  int unsigned slot_pos;
  int unsigned gen_pos;
  int unsigned idle_run;
  int unsigned slots_left;
  bit          held;
  int unsigned held_run;
  int unsigned queue_depth;
  int unsigned air_time;
  logic [15:0] sent_total;

  tick_beat_t    pending_ticks[$];
  station_beat_t expected_beats[$];
  tick_beat_t    next_tick;
  station_beat_t seen_beat;
  station_beat_t due_beat;

  int unsigned sender_wait;
  int unsigned sender_calm;
  int unsigned receiver_wait;
  int unsigned receiver_calm;
  int unsigned results_seen;
  int unsigned hold_left;
  bit          hold_taken;
  int unsigned failures;

  function automatic void enqueue_tick(input tick_beat_t beat);
    pending_ticks.insert(pending_ticks.size(), beat);
  endfunction

  function automatic void enqueue_beat(input station_beat_t beat);
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  function automatic bit idle_met(input int unsigned count, input int unsigned sl);
    return count >= 255 || count * sl >= 2 * sl + aifs_q;
  endfunction

  function automatic int unsigned sat8_inc(input int unsigned v);
    return (v >= 255) ? 255 : v + 1;
  endfunction

  // Mostly a random wait per beat, with occasional runs of back-to-back beats.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void note_failure(input string why, input station_beat_t want,
                                       input station_beat_t got);
    failures++;
    if (failures <= SHOWN_LIMIT) begin
      $display("[%0t] %s: expected mode %0d start %0d backoff %0d pending %0d sent %0d",
               $time, why, want.mac_mode, want.tx_start, want.backoff_left,
               want.pending_packets, want.sent_count);
      $display("  got mode %0d start %0d backoff %0d pending %0d sent %0d",
               got.mac_mode, got.tx_start, got.backoff_left, got.pending_packets,
               got.sent_count);
    end
  endfunction

  // One microsecond tick of the station; queues the state beat that it must produce.
  task automatic advance_station(input logic busy, input logic [15:0] rnd);
    int unsigned   sl;
    int unsigned   pi;
    int unsigned   td;
    bit            at_boundary;
    bit            phase_reset;
    bit            count_down;
    station_beat_t want;
    sl = (slot_len_q == 0) ? 1 : slot_len_q;
    pi = (interval_q == 0) ? 1 : interval_q;
    td = (tx_dur_q == 0) ? 1 : tx_dur_q;
    at_boundary = (slot_pos == 0);
    phase_reset = 1'b0;
    count_down = 1'b0;
    want.tx_start = 1'b0;

    if (gen_pos == 0 && queue_depth < 255) queue_depth++;
    gen_pos = (gen_pos + 1 >= pi) ? 0 : gen_pos + 1;

    case (stn_mode)
      MAC_BACKOFF: begin
        if (at_boundary) begin
          if (busy) begin
            held = 1'b1;
            held_run = 0;
          end else if (!held) begin
            count_down = 1'b1;
          end else begin
            held_run = sat8_inc(held_run);
            if (idle_met(held_run, sl)) begin
              held = 1'b0;
              count_down = 1'b1;
            end
          end
          if (count_down) begin
            if (slots_left != 0) slots_left--;
            if (slots_left == 0 && queue_depth != 0) begin
              stn_mode = MAC_TX;
              air_time = 0;
              queue_depth--;
              sent_total++;
              want.tx_start = 1'b1;
            end
          end
        end
      end
      MAC_TX: begin
        if (air_time < 16'hFFFF) air_time++;
        // The first sensing boundary comes one slot after the tick that ends the frame.
        if (air_time >= td) begin
          stn_mode = MAC_SENSE;
          idle_run = 0;
          slot_pos = (sl == 1) ? 0 : 1;
          phase_reset = 1'b1;
        end
      end
      default: begin
        if (at_boundary) begin
          if (busy) begin
            idle_run = 0;
          end else begin
            idle_run = sat8_inc(idle_run);
            if (idle_met(idle_run, sl)) begin
              stn_mode = MAC_BACKOFF;
              slots_left = rnd % CW + 2;
              held = 1'b0;
              held_run = 0;
            end
          end
        end
      end
    endcase

    if (!phase_reset) slot_pos = (slot_pos + 1 >= sl) ? 0 : slot_pos + 1;

    want.mac_mode = stn_mode;
    want.backoff_left = slots_left[4:0];
    want.pending_packets = queue_depth[7:0];
    want.sent_count = sent_total;
    enqueue_beat(want);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [19:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SLOT_LEN:    slot_len_q = data[7:0];
      CFG_AIFS_EXTRA:  aifs_q = data[7:0];
      CFG_TX_DURATION: tx_dur_q = data[15:0];
      default:         interval_q = data;
    endcase
  endtask

  // Waits until every tick has been taken and every state beat has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tick_ch.valid || expected_beats.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_runs(input int unsigned count, input int unsigned idle_max,
                            input int unsigned busy_max);
    int unsigned left;
    int unsigned len;
    logic        busy;
    left = count;
    while (left != 0) begin
      busy = $urandom_range(0, 1);
      len = busy ? $urandom_range(1, busy_max) : $urandom_range(1, idle_max);
      if (len > left) len = left;
      // An odd flipped tick breaks up the otherwise clean runs.
      repeat (len)
        enqueue_tick({busy ^ ($urandom_range(0, 15) == 0), 16'($urandom)});
      left -= len;
    end
  endtask

  task automatic run_phase(input logic [7:0] slot, input logic [7:0] aifs,
                           input logic [15:0] txd, input logic [19:0] pint,
                           input int unsigned count, input int unsigned idle_max,
                           input int unsigned busy_max);
    wait_drained();
    write_reg(CFG_SLOT_LEN, 20'(slot));
    write_reg(CFG_AIFS_EXTRA, 20'(aifs));
    write_reg(CFG_TX_DURATION, 20'(txd));
    write_reg(CFG_PACKET_INTERVAL, pint);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    queue_runs(count, idle_max, busy_max);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Tick driver.
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      sender_wait = 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        advance_station(tick_ch.channel_busy, tick_ch.random_value);
        sender_wait = draw_wait(sender_calm);
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (sender_wait == 0 && pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          tick_ch.valid <= 1'b1;
          tick_ch.channel_busy <= next_tick.busy;
          tick_ch.random_value <= next_tick.rnd;
        end else begin
          tick_ch.valid <= 1'b0;
          if (sender_wait != 0) sender_wait--;
        end
      end
    end
  end

  // One long stall of the result side, so that the station fills up and stops taking ticks.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_taken && results_seen >= HOLD_AFTER) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      receiver_wait = 0;
      results_seen <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen_beat = {result_ch.mac_mode, result_ch.tx_start, result_ch.backoff_left,
                     result_ch.pending_packets, result_ch.sent_count};
        if (expected_beats.size() == 0) begin
          note_failure("state beat with nothing expected", '0, seen_beat);
        end else begin
          due_beat = expected_beats.pop_front();
          if (due_beat.mac_mode !== seen_beat.mac_mode ||
              due_beat.tx_start !== seen_beat.tx_start ||
              due_beat.backoff_left !== seen_beat.backoff_left ||
              due_beat.pending_packets !== seen_beat.pending_packets ||
              due_beat.sent_count !== seen_beat.sent_count)
            note_failure("state beat differs", due_beat, seen_beat);
        end
        results_seen <= results_seen + 1;
        receiver_wait = draw_wait(receiver_calm);
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
      end else if (receiver_wait != 0) begin
        receiver_wait--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("csma_backoff_station verification failed");
    $finish;
  end

  initial begin
    int unsigned i;
    logic [15:0] r;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.channel_busy = 1'b0;
    tick_ch.random_value = '0;
    result_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    slot_len_q = SLOT_LEN_RESET;
    aifs_q = AIFS_EXTRA_RESET;
    tx_dur_q = TX_DURATION_RESET;
    interval_q = PACKET_INTERVAL_RESET;
    stn_mode = MAC_SENSE;
    slot_pos = 0;
    gen_pos = 0;
    idle_run = 0;
    slots_left = 0;
    held = 1'b0;
    held_run = 0;
    queue_depth = 0;
    air_time = 0;
    sent_total = '0;
    sender_calm = 0;
    receiver_calm = 0;
    failures = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: random values at their edges, busy ticks on and off a slot boundary.
    for (i = 0; i < 24; i++) begin
      case (i % 6)
        0:       r = 16'h0000;
        1:       r = 16'hFFFF;
        2:       r = 16'd14;
        3:       r = 16'd15;
        4:       r = 16'h5555;
        default: r = 16'hAAAA;
      endcase
      enqueue_tick({1'(i == 13 || i == 14 || i == 20), r});
    end

    run_phase(8'd1, 8'd0, 16'd1, 20'd1, 60, 12, 3);
    run_phase(8'd2, 8'd3, 16'd5, 20'd3, 60, 20, 4);
    // Zero slot length, duration and interval all behave as one.
    run_phase(8'd0, 8'd1, 16'd0, 20'd0, 40, 10, 2);
    run_phase(8'd255, 8'd255, 16'd65535, 20'd1048575, 30, 30, 2);
    // Slot and generator phases left beyond the new limits must wrap.
    run_phase(8'd3, 8'd2, 16'd4, 20'd5, 40, 20, 3);
    // Leaves the station in the middle of a very long frame.
    run_phase(8'd1, 8'd0, 16'd60000, 20'd1, 40, 12, 3);

    // The shorter duration ends that frame at once. With one-tick slots and the largest
    // AIFS only a saturated idle count reaches the required idle time, first while
    // sensing and then while frozen; meanwhile the queue fills to its limit.
    run_phase(8'd1, 8'd255, 16'd2, 20'd1, 0, 1, 1);
    // The largest backoff draw leaves room for the busy tick to land before it runs out.
    repeat (260) enqueue_tick({1'b0, 16'(15 * $urandom_range(0, 4368) + 14)});
    enqueue_tick({1'b1, 16'($urandom)});
    repeat (260) enqueue_tick({1'b0, 16'($urandom)});
    queue_runs(40, 30, 3);

    wait_drained();
    if (failures == 0 && expected_beats.size() == 0)
      $display("csma_backoff_station verification clean");
    else
      $display("csma_backoff_station verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/csma_pkg.sv
design/csma_tick_if.sv
design/csma_result_if.sv
design/csma_cfg_regs.sv
design/csma_mod_unit.sv
design/csma_mac_core.sv
design/csma_backoff_station.sv
tb/testbench.sv
